>>> design/md4f_pkg.sv
// Shared types, constants and helper functions for the MD4 fold one-way step.
// Used by md4f_round, md4f_fold and the top level md4_fold_one_way_step.
package md4f_pkg;

  localparam int unsigned KeyWidth  = 64;
  localparam int unsigned NumSteps  = 48;
  localparam int unsigned StepWidth = 6;
  localparam logic [31:0] MsgBits   = 32'd64;

  localparam logic [3:0][31:0] InitState = {
    32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [3:0] WordOrder [NumSteps] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
    4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
    4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
    4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
  };

  typedef struct packed {
    logic [KeyWidth-1:0] key;
    logic [3:0][31:0]    st;
  } md4f_data_t;

  function automatic logic [31:0] msg_word(logic [KeyWidth-1:0] key, logic [3:0] idx);
    logic [31:0] w;
    case (idx)
      4'd0:    w = key[31:0];
      4'd1:    w = key[63:32];
      4'd2:    w = 32'h00000080;
      4'd14:   w = MsgBits;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  function automatic logic [4:0] rot_amount(logic [1:0] rnd, logic [1:0] pos);
    logic [4:0] s;
    case (rnd)
      2'd0: begin
        case (pos)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd7;
          2'd2:    s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      2'd1: begin
        case (pos)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd5;
          2'd2:    s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        case (pos)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd9;
          2'd2:    s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic logic [31:0] round_add(logic [1:0] rnd);
    logic [31:0] k;
    case (rnd)
      2'd0:    k = 32'h00000000;
      2'd1:    k = 32'h5A827999;
      default: k = 32'h6ED9EBA1;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] mix(logic [1:0] rnd, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z);
    logic [31:0] f;
    case (rnd)
      2'd0:    f = (x & y) | (~x & z);
      2'd1:    f = (x & y) | (x & z) | (y & z);
      default: f = x ^ y ^ z;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(logic [31:0] v, logic [4:0] s);
    logic [63:0] dbl;
    dbl = {v, v} << s;
    return dbl[63:32];
  endfunction

endpackage

>>> design/md4f_round.sv
// One registered MD4 compression step; the step number arrives as a constant input.
// Depends on md4f_pkg for the state type, tables and step functions.
module md4f_round (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [md4f_pkg::StepWidth-1:0]        step_i,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  md4f_pkg::md4f_data_t                  data_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output md4f_pkg::md4f_data_t                  data_o
);

  logic                 valid_q;
  md4f_pkg::md4f_data_t data_q, data_d;
  logic [1:0]           rnd, pos, t;
  logic [31:0]          f, w, sum;

  assign ready_o = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    rnd = step_i[5:4];
    pos = step_i[1:0];
    t   = ~pos + 2'd1;
    f   = md4f_pkg::mix(rnd, data_i.st[t + 2'd1], data_i.st[t + 2'd2], data_i.st[t + 2'd3]);
    w   = md4f_pkg::msg_word(data_i.key,
                             md4f_pkg::WordOrder[step_i]);
    sum = data_i.st[t] + f + w + md4f_pkg::round_add(rnd);
    data_d = data_i;
    data_d.st[t] = md4f_pkg::rotl32(sum, md4f_pkg::rot_amount(rnd, pos));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

>>> design/md4f_fold.sv
// Final feed-forward add of the initial state, fold to 64 bits, and output register.
// Depends on md4f_pkg for the state type and initial state constant.
module md4f_fold (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  md4f_pkg::md4f_data_t                data_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic [md4f_pkg::KeyWidth-1:0]       key_o
);

  logic                          valid_q;
  logic [md4f_pkg::KeyWidth-1:0] key_q, key_d;
  logic [3:0][31:0]              fin;

  assign ready_o = ~valid_q | ~stall_i;
  assign valid_o = valid_q;
  assign key_o   = key_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fin[i] = data_i.st[i] + md4f_pkg::InitState[i];
    end
    key_d = {fin[1] ^ fin[3], fin[0] ^ fin[2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      key_q <= key_d;
    end
  end

endmodule

>>> design/md4_fold_one_way_step.sv
// MD4 fold one-way step: 48 pipeline stages, one MD4 step each, then a fold stage.
// Each accepted item passes every step stage register and then the fold register.
// One item per cycle unless output stalls; a step stage is a four-input add and a rotate.
// Empty stages fill even while the output is stalled, so input stalls only when all is full.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; data holds no reset.
// Depends on md4f_pkg, md4f_round and md4f_fold.
module md4_fold_one_way_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [md4f_pkg::KeyWidth-1:0] key_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [md4f_pkg::KeyWidth-1:0] key_out_o
);

  localparam int unsigned N = md4f_pkg::NumSteps;

  logic                 vld [N+1];
  logic                 rdy [N+1];
  md4f_pkg::md4f_data_t dat [N+1];
  logic [N-1:0]         stage_vld;

  assign vld[0]       = in_valid_i;
  assign dat[0].key   = key_in_i;
  assign dat[0].st    = md4f_pkg::InitState;
  assign in_stall_o   = ~rdy[0];

  for (genvar g = 0; g < N; g++) begin : g_step
    md4f_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (md4f_pkg::StepWidth'(g)),
      .valid_i (vld[g]),
      .ready_o (rdy[g]),
      .data_i  (dat[g]),
      .valid_o (vld[g+1]),
      .ready_i (rdy[g+1]),
      .data_o  (dat[g+1])
    );
    assign stage_vld[g] = vld[g+1];
  end

  md4f_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[N]),
    .ready_o (rdy[N]),
    .data_i  (dat[N]),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .key_o   (key_out_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&stage_vld) && out_valid_o && out_stall_i)
    else $error("input stalled while the pipeline has room");

  a_out_from_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(stage_vld[N-1]))
    else $error("result appeared without an item in the last step stage");

  a_no_stall_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with the output register empty");

endmodule
